/* rtl/core/tcf_pkg.sv */
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, sizes and helpers for the two-class oldest-first queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

  localparam int CAPACITY = 1024;
  localparam int TAG_BITS = 16;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int OP_W     = 2;
  localparam int TAG_W    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ_ANY = 2'd1,
    OP_DEQ_DOG = 2'd2,
    OP_DEQ_CAT = 2'd3
  } op_t;

  typedef struct packed {
    logic                we;
    logic [PTR_W-1:0]    waddr;
    logic [TAG_BITS-1:0] wdata;
    logic                re;
    logic [PTR_W-1:0]    raddr;
  } mem_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] cat_count;
    logic [CNT_W-1:0] dog_count;
    logic             busy;
  } status_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/two_class_fifo_oldest_first_top.sv */
// ----------------------------------------------------------------------------
// two_class_fifo_oldest_first_top
// Cat and dog tag queues sharing one capacity; dequeue by class or oldest.
// ----------------------------------------------------------------------------
// Enqueue: no result beat; the queue stays idle, so the next beat is taken without a wait.
// Dequeue: accept starts a registered read of both queue memories; the result
//   beat enters the output register once it is free, and no input is taken until then.
// Input is taken while a result beat waits in the output register.
// Reset clears pointers, counts and control; the queue memories are not
//   cleared and need no clearing pass.
`default_nettype none

module two_class_fifo_oldest_first_top (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [tcf_pkg::OP_W-1:0]  in_op,
  input  wire logic [tcf_pkg::TAG_W-1:0] in_tag,
  input  wire logic                      in_kind,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic                      out_found,
  output      logic [tcf_pkg::TAG_W-1:0] out_tag,
  output      logic                      out_kind
);

  tcf_pkg::mem_req_t            cat_req, dog_req;
  logic [tcf_pkg::TAG_BITS-1:0] cat_rdata, dog_rdata;
  tcf_pkg::status_t             status;

  tcf_ram #(
    .WIDTH (tcf_pkg::TAG_BITS),
    .DEPTH (tcf_pkg::CAPACITY)
  ) u_cat_ram (
    .clk   (clk),
    .we    (cat_req.we),
    .waddr (cat_req.waddr),
    .wdata (cat_req.wdata),
    .re    (cat_req.re),
    .raddr (cat_req.raddr),
    .rdata (cat_rdata)
  );

  tcf_ram #(
    .WIDTH (tcf_pkg::TAG_BITS),
    .DEPTH (tcf_pkg::CAPACITY)
  ) u_dog_ram (
    .clk   (clk),
    .we    (dog_req.we),
    .waddr (dog_req.waddr),
    .wdata (dog_req.wdata),
    .re    (dog_req.re),
    .raddr (dog_req.raddr),
    .rdata (dog_rdata)
  );

  tcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_tag    (in_tag),
    .in_kind   (in_kind),
    .cat_req   (cat_req),
    .dog_req   (dog_req),
    .cat_rdata (cat_rdata),
    .dog_rdata (dog_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_found (out_found),
    .out_tag   (out_tag),
    .out_kind  (out_kind),
    .status    (status)
  );

  a_cap_held: assert property (@(posedge clk) disable iff (!rst_n)
    (tcf_pkg::SUM_W'(status.cat_count) + tcf_pkg::SUM_W'(status.dog_count))
      <= tcf_pkg::SUM_W'(tcf_pkg::CAPACITY))
    else $error("queue counts exceed shared capacity");

  a_empty_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_tag == '0 && out_kind == 1'b0))
    else $error("not-found beat carries nonzero payload");

  a_deq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_op != tcf_pkg::OP_ENQ) |=> (!in_ready && status.busy))
    else $error("dequeue accepted without read cycle");

  a_no_mem_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !((cat_req.we && cat_req.re) || (dog_req.we && dog_req.re)))
    else $error("queue memory read and write in the same cycle");

endmodule

`default_nettype wire

/* rtl/core/tcf_ram.sv */
// ----------------------------------------------------------------------------
// tcf_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/tcf_ctrl.sv */
// ----------------------------------------------------------------------------
// tcf_ctrl
// Queue pointers, shared-capacity check, head selection and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcf_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [tcf_pkg::OP_W-1:0]     in_op,
  input  wire logic [tcf_pkg::TAG_W-1:0]    in_tag,
  input  wire logic                         in_kind,
  output      tcf_pkg::mem_req_t            cat_req,
  output      tcf_pkg::mem_req_t            dog_req,
  input  wire logic [tcf_pkg::TAG_BITS-1:0] cat_rdata,
  input  wire logic [tcf_pkg::TAG_BITS-1:0] dog_rdata,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic                         out_found,
  output      logic [tcf_pkg::TAG_W-1:0]    out_tag,
  output      logic                         out_kind,
  output      tcf_pkg::status_t             status
);

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t                        state_r, state_nxt;
  tcf_pkg::op_t                  op_r, op_nxt;
  logic [tcf_pkg::PTR_W-1:0]     cat_head_r, cat_head_nxt, cat_tail_r, cat_tail_nxt;
  logic [tcf_pkg::PTR_W-1:0]     dog_head_r, dog_head_nxt, dog_tail_r, dog_tail_nxt;
  logic [tcf_pkg::CNT_W-1:0]     cat_cnt_r, cat_cnt_nxt, dog_cnt_r, dog_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [tcf_pkg::TAG_W-1:0]     out_tag_r, out_tag_nxt;
  logic                          out_kind_r, out_kind_nxt;

  logic                          acc;
  logic                          full;
  logic                          cat_ne, dog_ne;
  logic                          pick_dog;
  logic                          out_free;
  logic [tcf_pkg::TAG_BITS-1:0]  wtag;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign full     = (tcf_pkg::SUM_W'(cat_cnt_r) + tcf_pkg::SUM_W'(dog_cnt_r))
                    >= tcf_pkg::SUM_W'(tcf_pkg::CAPACITY);
  assign cat_ne   = (cat_cnt_r != '0);
  assign dog_ne   = (dog_cnt_r != '0);
  assign out_free = !out_valid_r || out_ready;
  assign wtag     = tcf_pkg::TAG_BITS'(in_tag);

  always_comb begin
    case (op_r)
      tcf_pkg::OP_DEQ_DOG: pick_dog = 1'b1;
      tcf_pkg::OP_DEQ_CAT: pick_dog = 1'b0;
      tcf_pkg::OP_DEQ_ANY: pick_dog = (cat_ne && dog_ne) ? !(cat_rdata < dog_rdata) : !cat_ne;
      default:             pick_dog = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cat_head_nxt  = cat_head_r;
    cat_tail_nxt  = cat_tail_r;
    cat_cnt_nxt   = cat_cnt_r;
    dog_head_nxt  = dog_head_r;
    dog_tail_nxt  = dog_tail_r;
    dog_cnt_nxt   = dog_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_tag_nxt   = out_tag_r;
    out_kind_nxt  = out_kind_r;

    cat_req       = '{we: 1'b0, waddr: cat_tail_r, wdata: wtag, re: 1'b0, raddr: cat_head_r};
    dog_req       = '{we: 1'b0, waddr: dog_tail_r, wdata: wtag, re: 1'b0, raddr: dog_head_r};

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_op == tcf_pkg::OP_ENQ) begin
            if (!full) begin
              if (in_kind) begin
                dog_req.we   = 1'b1;
                dog_tail_nxt = tcf_pkg::ring_next(dog_tail_r);
                dog_cnt_nxt  = dog_cnt_r + tcf_pkg::CNT_W'(1);
              end else begin
                cat_req.we   = 1'b1;
                cat_tail_nxt = tcf_pkg::ring_next(cat_tail_r);
                cat_cnt_nxt  = cat_cnt_r + tcf_pkg::CNT_W'(1);
              end
            end
          end else begin
            cat_req.re = 1'b1;
            dog_req.re = 1'b1;
            op_nxt     = tcf_pkg::op_t'(in_op);
            state_nxt  = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (pick_dog && dog_ne) begin
            out_found_nxt = 1'b1;
            out_tag_nxt   = tcf_pkg::TAG_W'(dog_rdata);
            out_kind_nxt  = 1'b1;
            dog_head_nxt  = tcf_pkg::ring_next(dog_head_r);
            dog_cnt_nxt   = dog_cnt_r - tcf_pkg::CNT_W'(1);
          end else if (!pick_dog && cat_ne) begin
            out_found_nxt = 1'b1;
            out_tag_nxt   = tcf_pkg::TAG_W'(cat_rdata);
            out_kind_nxt  = 1'b0;
            cat_head_nxt  = tcf_pkg::ring_next(cat_head_r);
            cat_cnt_nxt   = cat_cnt_r - tcf_pkg::CNT_W'(1);
          end else begin
            out_found_nxt = 1'b0;
            out_tag_nxt   = '0;
            out_kind_nxt  = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= tcf_pkg::OP_ENQ;
      cat_head_r  <= '0;
      cat_tail_r  <= '0;
      cat_cnt_r   <= '0;
      dog_head_r  <= '0;
      dog_tail_r  <= '0;
      dog_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cat_head_r  <= cat_head_nxt;
      cat_tail_r  <= cat_tail_nxt;
      cat_cnt_r   <= cat_cnt_nxt;
      dog_head_r  <= dog_head_nxt;
      dog_tail_r  <= dog_tail_nxt;
      dog_cnt_r   <= dog_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_found_r <= out_found_nxt;
    out_tag_r   <= out_tag_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_tag   = out_tag_r;
  assign out_kind  = out_kind_r;
  assign status    = '{cat_count: cat_cnt_r, dog_count: dog_cnt_r,
                       busy: (state_r == ST_READ)};

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the two-class oldest-first tag queue. Directed beats cover empty
// dequeues, tag extremes, equal heads and the full shelf; random beats then
// grow and drain both queues under random gaps and a long output stall.
// A shadow of both queues predicts every dequeue beat.
// ----------------------------------------------------------------------------
module tb;
  import tcf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic             found;
    logic [TAG_W-1:0] tag;
    logic             kind;
  } pop_beat_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  in_op = '0;
  logic [TAG_W-1:0] in_tag = '0;
  logic             in_kind = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             out_found;
  logic [TAG_W-1:0] out_tag;
  logic             out_kind;

  logic [TAG_W-1:0] cat_line[$];
  logic [TAG_W-1:0] dog_line[$];
  pop_beat_t        pop_due[$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  int  rx_hold = 0;
  int  rx_wait = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  logic [TAG_W-1:0] arrival;

  two_class_fifo_oldest_first_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_tag    (in_tag),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_found (out_found),
    .out_tag   (out_tag),
    .out_kind  (out_kind)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void shelf_step(op_t op, logic [TAG_W-1:0] tag, logic kind);
    logic [TAG_W-1:0] keep;
    pop_beat_t        res;
    bit               take_dog;
    keep = tag & TAG_W'((64'd1 << TAG_BITS) - 64'd1);
    take_dog = 1'b0;
    case (op)
      OP_ENQ: begin
        if (cat_line.size() + dog_line.size() < CAPACITY) begin
          if (kind) dog_line.push_back(keep);
          else cat_line.push_back(keep);
        end
        return;
      end
      OP_DEQ_DOG: take_dog = 1'b1;
      OP_DEQ_CAT: take_dog = 1'b0;
      default: begin
        if (cat_line.size() != 0 && dog_line.size() != 0)
          take_dog = !(cat_line[0] < dog_line[0]);
        else
          take_dog = (cat_line.size() == 0);
      end
    endcase
    res = '0;
    if (take_dog && dog_line.size() != 0) begin
      res.found = 1'b1;
      res.tag   = dog_line.pop_front();
      res.kind  = 1'b1;
    end else if (!take_dog && cat_line.size() != 0) begin
      res.found = 1'b1;
      res.tag   = cat_line.pop_front();
      res.kind  = 1'b0;
    end
    pop_due.push_back(res);
  endfunction

  // Check the result beat before predicting the input beat of the same edge.
  always @(posedge clk) begin
    pop_beat_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready) begin
        if (pop_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("tb: unexpected beat found=%0b tag=%h kind=%0b",
                     out_found, out_tag, out_kind);
        end else begin
          want = pop_due.pop_front();
          if (out_found !== want.found || out_tag !== want.tag ||
              out_kind !== want.kind) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("tb: mismatch exp found=%0b tag=%h kind=%0b, got found=%0b tag=%h kind=%0b",
                       want.found, want.tag, want.kind, out_found, out_tag, out_kind);
          end
        end
      end
      if (in_valid && in_ready === 1'b1)
        shelf_step(op_t'(in_op), in_tag, in_kind);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        rx_wait = pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input op_t op, input logic [TAG_W-1:0] tag, input logic kind);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_tag   <= tag;
    in_kind  <= kind;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic test_directed();
    logic [TAG_W-1:0] junk;
    junk = TAG_W'($urandom);
    send_beat(OP_DEQ_ANY, junk, 1'b1);
    send_beat(OP_DEQ_DOG, ~junk, 1'b0);
    send_beat(OP_DEQ_CAT, junk, 1'b1);
    send_beat(OP_ENQ, 16'hFFFF, 1'b0);
    send_beat(OP_ENQ, 16'h0000, 1'b1);
    send_beat(OP_DEQ_ANY, junk, 1'b0);
    send_beat(OP_DEQ_ANY, ~junk, 1'b1);
    send_beat(OP_ENQ, 16'h1234, 1'b0);
    send_beat(OP_ENQ, 16'h1234, 1'b1);
    send_beat(OP_DEQ_ANY, junk, 1'b0);
    send_beat(OP_DEQ_ANY, junk, 1'b0);
    send_beat(OP_ENQ, 16'h0003, 1'b0);
    send_beat(OP_ENQ, 16'h0009, 1'b1);
    send_beat(OP_DEQ_ANY, ~junk, 1'b1);
    send_beat(OP_DEQ_ANY, junk, 1'b1);
    send_beat(OP_ENQ, 16'h0005, 1'b1);
    send_beat(OP_ENQ, 16'h0007, 1'b0);
    send_beat(OP_DEQ_CAT, junk, 1'b1);
    send_beat(OP_DEQ_DOG, junk, 1'b0);
    send_beat(OP_DEQ_DOG, ~junk, 1'b1);
    send_beat(OP_DEQ_CAT, ~junk, 1'b0);
  endtask

  task automatic test_full_shelf();
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    for (int i = 0; i < CAPACITY + 3; i++)
      send_beat(OP_ENQ, TAG_W'(i), 1'($urandom));
    send_beat(OP_DEQ_CAT, '0, 1'b0);
    send_beat(OP_ENQ, 16'hFFFF, 1'b1);
    send_beat(OP_ENQ, 16'hAAAA, 1'b0);
    for (int i = 0; i < 200; i++)
      send_beat(OP_DEQ_ANY, TAG_W'($urandom), 1'($urandom));
    tx_calm = 1'b0;
  endtask

  task automatic test_backpressure();
    rx_hold = 300;
    for (int i = 0; i < 60; i++) begin
      if (i < 25) send_beat(OP_ENQ, arrival++, 1'($urandom));
      else send_beat(op_t'($urandom_range(1, 3)), TAG_W'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_random_mix();
    int               enq_pct;
    int               r;
    logic [TAG_W-1:0] tag;
    for (int phase = 0; phase < 2; phase++) begin
      case ($urandom_range(0, 2))
        0: enq_pct = 75;
        1: enq_pct = 50;
        default: enq_pct = 30;
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 170; i++) begin
        r = $urandom_range(0, 99);
        if (r < 60) tag = arrival++;
        else if (r < 85) tag = TAG_W'($urandom);
        else tag = TAG_W'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < enq_pct)
          send_beat(OP_ENQ, tag, 1'($urandom));
        else
          send_beat(op_t'($urandom_range(1, 3)), tag, 1'($urandom));
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    arrival = TAG_W'($urandom);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_full_shelf();
    test_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    while (pop_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pop_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
